@@ rtl/cdm_pkg.sv @@
// Package for the color distance mask unit.
// Holds the shared constants, configuration register indexes, and the configuration and pipeline stage structs.
// No dependencies.
package cdm_pkg;

    localparam int CELL_COUNT = 8;
    localparam int PIX_W      = 8;
    localparam int LEVEL_W    = 8;
    localparam int REM_W      = 18;
    localparam int DSH_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FUZZ_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANTIALIAS_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_FIRST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REF_SECOND     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REF_THIRD      = 3'd6;

    localparam logic [7:0] FUZZ_RESET     = 8'd15;
    localparam logic [1:0] CHANNELS_RESET = 2'd3;
    localparam logic [7:0] LEVEL_FULL     = 8'd255;
    localparam logic [7:0] LEVEL_NONE     = 8'd0;

    typedef struct packed {
        logic [7:0] fuzz_threshold;
        logic       antialias_on;
        logic [1:0] color_channels;
        logic       alpha_present;
        logic [7:0] ref_first;
        logic [7:0] ref_second;
        logic [7:0] ref_third;
    } cdm_cfg_t;

    typedef struct packed {
        logic               valid;
        logic               ramp;
        logic [LEVEL_W-1:0] level;
        logic [REM_W-1:0]   rem;
        logic [DSH_W-1:0]   dsh;
        logic [LEVEL_W-1:0] quot;
    } cdm_stage_t;

endpackage

@@ rtl/cdm_interfaces.sv @@
// Channel interfaces of the color distance mask unit: pixel, mask and configuration.
// Depends on cdm_pkg.
interface cdm_pix_if import cdm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pix_first;
    logic [PIX_W-1:0] pix_second;
    logic [PIX_W-1:0] pix_third;
    logic [PIX_W-1:0] pix_alpha;

    modport source (output valid, output pix_first, output pix_second,
                    output pix_third, output pix_alpha, input ready);
    modport sink (input valid, input pix_first, input pix_second,
                  input pix_third, input pix_alpha, output ready);
endinterface

interface cdm_mask_if import cdm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] mask_level;

    modport source (output valid, output mask_level, input ready);
    modport sink (input valid, input mask_level, output ready);
endinterface

interface cdm_cfg_if import cdm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/color_distance_mask_unit.sv @@
// Color distance mask unit: top level with configuration registers and the cell chain.
// Depends on cdm_pkg, cdm_interfaces, cdm_front and cdm_cell.
// The chain is one front cell and eight divider cells, each divider cell giving one quotient bit.
// Throughput is one pixel per cycle; a stalled mask transaction freezes the whole chain.
// Reset loads the configuration reset values and clears all valid bits at once.
module color_distance_mask_unit
    import cdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cdm_pix_if.sink     pixel,
    cdm_mask_if.source  mask,
    cdm_cfg_if.sink     cfg
);

    cdm_cfg_t   cfg_reg;
    cdm_stage_t chain [CELL_COUNT+1];
    logic       advance;

    assign cfg.ready   = 1'b1;
    assign advance     = !chain[CELL_COUNT].valid || mask.ready;
    assign pixel.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{FUZZ_RESET, 1'b0, CHANNELS_RESET, 1'b0, 8'd0, 8'd0, 8'd0};
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FUZZ_THRESHOLD: cfg_reg.fuzz_threshold <= cfg.data;
                REG_ANTIALIAS_ON:   cfg_reg.antialias_on   <= cfg.data[0];
                REG_COLOR_CHANNELS: cfg_reg.color_channels <= cfg.data[1:0];
                REG_ALPHA_PRESENT:  cfg_reg.alpha_present  <= cfg.data[0];
                REG_REF_FIRST:      cfg_reg.ref_first      <= cfg.data;
                REG_REF_SECOND:     cfg_reg.ref_second     <= cfg.data;
                REG_REF_THIRD:      cfg_reg.ref_third      <= cfg.data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    cdm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .take       (pixel.valid),
        .cfg_q      (cfg_reg),
        .pix_first  (pixel.pix_first),
        .pix_second (pixel.pix_second),
        .pix_third  (pixel.pix_third),
        .pix_alpha  (pixel.pix_alpha),
        .stage_reg  (chain[0])
    );

    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        cdm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage_in  (chain[k]),
            .stage_reg (chain[k+1])
        );
    end

    assign mask.valid      = chain[CELL_COUNT].valid;
    assign mask.mask_level = chain[CELL_COUNT].ramp ? chain[CELL_COUNT].quot
                                                    : chain[CELL_COUNT].level;

`ifndef SYNTHESIS
    a_ramp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        chain[CELL_COUNT].valid && chain[CELL_COUNT].ramp |-> chain[CELL_COUNT].quot != 8'd0)
        else $error("ramp quotient is zero");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> chain[0].valid)
        else $error("accepted pixel did not enter the front cell");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain[CELL_COUNT]))
        else $error("last cell changed during a stall");

    a_ramp_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        chain[CELL_COUNT].valid && chain[CELL_COUNT].ramp
        |-> chain[CELL_COUNT].rem < {10'd0, cfg_reg.fuzz_threshold})
        else $error("ramp remainder not below divisor");
`endif

endmodule

@@ rtl/cdm_front.sv @@
// Front cell: channel distance, level decision and ramp numerator for one pixel.
// Depends on cdm_pkg.
module cdm_front
    import cdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             take,
    input  cdm_cfg_t         cfg_q,
    input  logic [PIX_W-1:0] pix_first,
    input  logic [PIX_W-1:0] pix_second,
    input  logic [PIX_W-1:0] pix_third,
    input  logic [PIX_W-1:0] pix_alpha,
    output cdm_stage_t       stage_reg
);

    logic [7:0]       diff_first;
    logic [7:0]       diff_second;
    logic [7:0]       diff_third;
    logic [7:0]       chan_dist;
    logic [7:0]       thr;
    logic [9:0]       dist_x2;
    logic [9:0]       thr_x3;
    cdm_stage_t       stage_next;

    always_comb
    begin
        diff_first  = (cfg_q.ref_first >= pix_first) ? cfg_q.ref_first - pix_first
                                                      : pix_first - cfg_q.ref_first;
        diff_second = (cfg_q.ref_second >= pix_second) ? cfg_q.ref_second - pix_second
                                                        : pix_second - cfg_q.ref_second;
        diff_third  = (cfg_q.ref_third >= pix_third) ? cfg_q.ref_third - pix_third
                                                      : pix_third - cfg_q.ref_third;
        chan_dist = 8'd0;
        if (cfg_q.color_channels >= 2'd1 && diff_first > chan_dist)
        begin
            chan_dist = diff_first;
        end
        if (cfg_q.color_channels >= 2'd2 && diff_second > chan_dist)
        begin
            chan_dist = diff_second;
        end
        if (cfg_q.color_channels == 2'd3 && diff_third > chan_dist)
        begin
            chan_dist = diff_third;
        end

        thr     = cfg_q.fuzz_threshold;
        dist_x2 = {1'b0, chan_dist, 1'b0};
        thr_x3  = {2'b00, thr} + {1'b0, thr, 1'b0};

        stage_next       = '0;
        stage_next.valid = take;
        stage_next.rem   = {1'b0, thr, 9'd0} + {2'b00, thr, 8'd0} - {1'b0, chan_dist, 9'd0};
        stage_next.dsh   = {thr, 7'd0};
        priority if (cfg_q.alpha_present && pix_alpha == 8'd0)
        begin
            stage_next.level = LEVEL_NONE;
        end
        else if (cfg_q.antialias_on && thr != 8'd0)
        begin
            priority if (chan_dist <= thr)
            begin
                stage_next.level = LEVEL_FULL;
            end
            else if (dist_x2 >= thr_x3)
            begin
                stage_next.level = LEVEL_NONE;
            end
            else
            begin
                stage_next.ramp = 1'b1;
            end
        end
        else
        begin
            stage_next.level = (chan_dist > thr) ? LEVEL_NONE : LEVEL_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ rtl/cdm_cell.sv @@
// Divider cell: one restoring step of the ramp division, one quotient bit per cell.
// Depends on cdm_pkg.
module cdm_cell
    import cdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  cdm_stage_t stage_in,
    output cdm_stage_t stage_reg
);

    logic       fits;
    cdm_stage_t stage_next;

    always_comb
    begin
        fits       = stage_in.rem >= {{(REM_W-DSH_W){1'b0}}, stage_in.dsh};
        stage_next = stage_in;
        if (fits)
        begin
            stage_next.rem = stage_in.rem - {{(REM_W-DSH_W){1'b0}}, stage_in.dsh};
        end
        stage_next.quot = {stage_in.quot[LEVEL_W-2:0], fits};
        stage_next.dsh  = stage_in.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ test/color_distance_mask_unit_test.sv @@
// Self-checking testbench for color_distance_mask_unit: a scoreboard predicts the mask level of
// every accepted pixel and checks mask transactions in order under random idling and stalls.
// Depends on cdm_pkg, cdm_interfaces and the color_distance_mask_unit RTL.
module color_distance_mask_unit_test
    import cdm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY       = 9;
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int SETTINGS_PER_PHASE = 5;
    localparam int PIXELS_PER_SETTING = 30;
    localparam int PHASE_COUNT        = 4;
    localparam int SENDER_IDLE [PHASE_COUNT] = '{0, 76, 0, 25};
    localparam int RECEIVER_STALL [PHASE_COUNT] = '{0, 0, 76, 25};
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] pix_first;
        logic [PIX_W-1:0] pix_second;
        logic [PIX_W-1:0] pix_third;
        logic [PIX_W-1:0] pix_alpha;
    } pixel_t;

    class mask_scoreboard;
        cdm_cfg_t           shadow;
        logic [LEVEL_W-1:0] expected_levels [$];
        int                 errors;
        int                 pixels_seen;
        int                 levels_checked;
        int                 full_count;
        int                 ramp_count;
        int                 none_count;

        function new();
            shadow = '{FUZZ_RESET, 1'b0, CHANNELS_RESET, 1'b0, 8'd0, 8'd0, 8'd0};
            errors = 0;
            pixels_seen = 0;
            levels_checked = 0;
            full_count = 0;
            ramp_count = 0;
            none_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FUZZ_THRESHOLD: shadow.fuzz_threshold = value;
                REG_ANTIALIAS_ON:   shadow.antialias_on   = value[0];
                REG_COLOR_CHANNELS: shadow.color_channels = value[1:0];
                REG_ALPHA_PRESENT:  shadow.alpha_present  = value[0];
                REG_REF_FIRST:      shadow.ref_first      = value;
                REG_REF_SECOND:     shadow.ref_second     = value;
                REG_REF_THIRD:      shadow.ref_third      = value;
                default:            ;
            endcase
        endfunction

        function logic [LEVEL_W-1:0] predict_level(pixel_t p);
            logic [PIX_W-1:0] px [3];
            logic [PIX_W-1:0] rf [3];
            int unsigned      chan_dist;
            int unsigned      diff;
            int unsigned      t;
            px[0] = p.pix_first;
            px[1] = p.pix_second;
            px[2] = p.pix_third;
            rf[0] = shadow.ref_first;
            rf[1] = shadow.ref_second;
            rf[2] = shadow.ref_third;
            if (shadow.alpha_present && p.pix_alpha == 0)
                return LEVEL_NONE;
            chan_dist = 0;
            for (int c = 0; c < 3; c++)
            begin
                if (c < shadow.color_channels)
                begin
                    diff = (px[c] >= rf[c]) ? px[c] - rf[c] : rf[c] - px[c];
                    if (diff > chan_dist)
                        chan_dist = diff;
                end
            end
            t = shadow.fuzz_threshold;
            if (shadow.antialias_on && t != 0)
            begin
                if (chan_dist <= t)
                    return LEVEL_FULL;
                if (2 * chan_dist >= 3 * t)
                    return LEVEL_NONE;
                return LEVEL_W'((768 * t - 512 * chan_dist) / t);
            end
            return (chan_dist > t) ? LEVEL_NONE : LEVEL_FULL;
        endfunction

        function void note_pixel(pixel_t p);
            logic [LEVEL_W-1:0] level;
            level = predict_level(p);
            expected_levels.push_back(level);
            pixels_seen++;
            if (level == LEVEL_FULL)
                full_count++;
            else if (level == LEVEL_NONE)
                none_count++;
            else
                ramp_count++;
        endfunction

        function void check_level(logic [LEVEL_W-1:0] actual);
            logic [LEVEL_W-1:0] wanted;
            if (expected_levels.size() == 0)
            begin
                $error("mask_level: unexpected transaction, expected none, actual %0d", actual);
                errors++;
                return;
            end
            wanted = expected_levels.pop_front();
            levels_checked++;
            if (actual !== wanted)
            begin
                $error("mask_level mismatch: expected %0d, actual %0d", wanted, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles = 0;
    int   settings_count;

    mask_scoreboard sb = new();

    cdm_pix_if  pixel_ch ();
    cdm_mask_if mask_ch ();
    cdm_cfg_if  cfg_ch ();

    color_distance_mask_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .mask  (mask_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && mask_ch.valid && mask_ch.ready)
            sb.check_level(mask_ch.mask_level);
        mask_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_ch.valid && pixel_ch.ready) || (mask_ch.valid && mask_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                             input bit close_burst);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(idx, value);
        if (close_burst)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_setting(input cdm_cfg_t s);
        write_reg(REG_FUZZ_THRESHOLD, s.fuzz_threshold, 1'b0);
        write_reg(REG_ANTIALIAS_ON, {7'($urandom), s.antialias_on}, 1'b0);
        write_reg(REG_COLOR_CHANNELS, {6'($urandom), s.color_channels}, 1'b0);
        write_reg(REG_ALPHA_PRESENT, {7'($urandom), s.alpha_present}, 1'b0);
        write_reg(REG_REF_FIRST, s.ref_first, 1'b0);
        write_reg(REG_REF_SECOND, s.ref_second, 1'b0);
        write_reg(REG_REF_THIRD, s.ref_third, 1'b1);
        settings_count++;
    endtask

    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid      <= 1'b1;
        pixel_ch.pix_first  <= p.pix_first;
        pixel_ch.pix_second <= p.pix_second;
        pixel_ch.pix_third  <= p.pix_third;
        pixel_ch.pix_alpha  <= p.pix_alpha;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    task automatic wait_drained();
        pixel_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    function automatic cdm_cfg_t random_setting();
        cdm_cfg_t s;
        int       pick;
        pick = $urandom_range(9);
        case (pick)
            0:       s.fuzz_threshold = 8'd0;
            1:       s.fuzz_threshold = 8'd255;
            2:       s.fuzz_threshold = 8'd1;
            3, 4:    s.fuzz_threshold = 8'($urandom_range(40));
            default: s.fuzz_threshold = 8'($urandom_range(255));
        endcase
        pick = $urandom_range(9);
        s.color_channels = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd2 : (pick < 5) ? 2'd1 : 2'd3;
        s.antialias_on  = 1'($urandom_range(1));
        s.alpha_present = 1'($urandom_range(1));
        s.ref_first     = 8'($urandom_range(255));
        s.ref_second    = 8'($urandom_range(255));
        s.ref_third     = 8'($urandom_range(255));
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] near_value(input logic [PIX_W-1:0] center, input int span);
        int v;
        if ($urandom_range(3) == 0)
            return PIX_W'($urandom_range(255));
        v = int'(center) + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return PIX_W'(v);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int     span;
        span = sb.shadow.fuzz_threshold + sb.shadow.fuzz_threshold / 2 + 2;
        p.pix_first  = near_value(sb.shadow.ref_first, span);
        p.pix_second = near_value(sb.shadow.ref_second, span);
        p.pix_third  = near_value(sb.shadow.ref_third, span);
        p.pix_alpha  = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
        return p;
    endfunction

    initial
    begin
        rst_n               <= 1'b0;
        pixel_ch.valid      <= 1'b0;
        pixel_ch.pix_first  <= '0;
        pixel_ch.pix_second <= '0;
        pixel_ch.pix_third  <= '0;
        pixel_ch.pix_alpha  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        idle_pct            = 0;
        stall_pct           = 0;
        settings_count      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel('{8'd15, 8'd15, 8'd15, 8'd0});
        send_pixel('{8'd16, 8'd0, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
        wait_drained();

        write_reg(REG_UNMAPPED, 8'hFF, 1'b1);
        repeat (2) @(posedge clk);
        send_pixel('{8'd16, 8'd0, 8'd0, 8'd1});
        wait_drained();

        program_setting('{8'd100, 1'b1, 2'd3, 1'b1, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd100, 8'd0, 8'd0, 8'd255});
        send_pixel('{8'd101, 8'd0, 8'd0, 8'd1});
        send_pixel('{8'd149, 8'd0, 8'd0, 8'd128});
        send_pixel('{8'd150, 8'd0, 8'd0, 8'd200});
        send_pixel('{8'd0, 8'd20, 8'd120, 8'd77});
        wait_drained();

        program_setting('{8'd0, 1'b1, 2'd3, 1'b0, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
        send_pixel('{8'd254, 8'd255, 8'd255, 8'd0});
        wait_drained();

        program_setting('{8'd0, 1'b0, 2'd0, 1'b0, 8'd10, 8'd20, 8'd30});
        send_pixel('{8'd255, 8'd0, 8'd255, 8'd0});
        wait_drained();

        program_setting('{8'd10, 1'b0, 2'd2, 1'b0, 8'd50, 8'd60, 8'd70});
        send_pixel('{8'd50, 8'd60, 8'd255, 8'd0});
        send_pixel('{8'd50, 8'd71, 8'd70, 8'd0});
        wait_drained();

        program_setting('{8'd10, 1'b0, 2'd1, 1'b0, 8'd50, 8'd60, 8'd70});
        send_pixel('{8'd60, 8'd255, 8'd0, 8'd0});
        wait_drained();

        program_setting('{8'd255, 1'b1, 2'd3, 1'b0, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
        wait_drained();

        program_setting('{8'd1, 1'b1, 2'd3, 1'b0, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd1, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd2, 8'd0, 8'd0, 8'd0});
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            idle_pct  = SENDER_IDLE[phase];
            stall_pct = RECEIVER_STALL[phase];
            for (int s = 0; s < SETTINGS_PER_PHASE; s++)
            begin
                program_setting(random_setting());
                for (int i = 0; i < PIXELS_PER_SETTING; i++)
                begin
                    if (s == 0 && i == PIXELS_PER_SETTING / 2)
                    begin
                        pixel_ch.valid <= 1'b0;
                        while (sb.pending() != 0)
                            @(posedge clk);
                    end
                    send_pixel(random_pixel());
                end
                wait_drained();
            end
        end

        $display("Covered %0d pixels under %0d register settings in %0d handshake phases.",
                 sb.pixels_seen, settings_count, PHASE_COUNT);
        $display("Levels checked: %0d (full %0d, ramp %0d, zero %0d).",
                 sb.levels_checked, sb.full_count, sb.ramp_count, sb.none_count);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
